FILE: design/erle_pkg.sv
package erle_pkg;

  localparam int BYTE_W            = 8;
  localparam int COUNT_W           = 9;
  localparam int OUT_TDATA_W       = 24;
  localparam int DEFAULT_RUN_OFFSET = 4;

  localparam logic [BYTE_W-1:0] LITERAL_ESCAPE_LEN = 8'hFF;

  typedef enum logic [1:0] {
    PH_AWAIT_CODE = 2'd0,
    PH_PLAIN      = 2'd1,
    PH_AWAIT_LEN  = 2'd2,
    PH_AWAIT_DATA = 2'd3
  } phase_t;

endpackage

FILE: design/escape_rle_byte_decoder_unit.sv
// escape run-length byte decoder
// an input transfer reaches its result on out_tvalid through
//   the input register, then decode into the result register
// throughput: one byte per cycle unless out_tready stalls; phase update is one compare step
// reset (rst_n low, synchronous): phase back to awaiting escape code, escape code and
//   pending length cleared, both pipeline registers emptied
module escape_rle_byte_decoder_unit
  import erle_pkg::*;
#(
  parameter int RUN_OFFSET = DEFAULT_RUN_OFFSET
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] stream_start
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [7:0] out_byte, [16:8] repeat_count, zero pad
);

  // input register
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_data_r;
  logic              s1_start_r;

  // decoder state
  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] escape_r, escape_nxt;
  logic [BYTE_W-1:0] pending_r, pending_nxt;

  // result register
  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic [COUNT_W-1:0] out_count_r;

  logic               s2_free;
  logic               s1_fire;
  logic               res_valid;
  logic [BYTE_W-1:0]  res_byte;
  logic [COUNT_W-1:0] res_count;
  logic [COUNT_W-1:0] run_count;

  assign s2_free   = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s2_free;
  assign in_tready = !s1_valid_r || s2_free;

  assign run_count = {1'b0, pending_r} + COUNT_W'(RUN_OFFSET);

  always_comb begin
    phase_nxt   = phase_r;
    escape_nxt  = escape_r;
    pending_nxt = pending_r;
    res_valid   = 1'b0;
    res_byte    = s1_data_r;
    res_count   = COUNT_W'(1);
    if (s1_start_r || phase_r == PH_AWAIT_CODE) begin
      // first byte of a stream is the escape code
      escape_nxt  = s1_data_r;
      pending_nxt = '0;
      phase_nxt   = PH_PLAIN;
    end else begin
      unique case (phase_r)
        PH_PLAIN: begin
          if (s1_data_r == escape_r) begin
            phase_nxt = PH_AWAIT_LEN;
          end else begin
            res_valid = 1'b1;
          end
        end
        PH_AWAIT_LEN: begin
          if (s1_data_r == LITERAL_ESCAPE_LEN) begin
            phase_nxt = PH_PLAIN;
            res_valid = 1'b1;
            res_byte  = escape_r;
          end else begin
            pending_nxt = s1_data_r;
            phase_nxt   = PH_AWAIT_DATA;
          end
        end
        PH_AWAIT_DATA: begin
          phase_nxt   = PH_PLAIN;
          pending_nxt = '0;
          res_count   = run_count;
          // zero count gives nothing
          res_valid   = (run_count != '0);
        end
        PH_AWAIT_CODE: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      phase_r     <= PH_AWAIT_CODE;
      escape_r    <= '0;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_fire) begin
        phase_r   <= phase_nxt;
        escape_r  <= escape_nxt;
        pending_r <= pending_nxt;
      end
      if (s2_free) begin
        out_valid_r <= s1_fire && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
    if (s1_fire && res_valid) begin
      out_byte_r  <= res_byte;
      out_count_r <= res_count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - COUNT_W - BYTE_W)'(0), out_count_r, out_byte_r};

  // every transfer that gives a result leaves the decoder in plain phase
  a_result_back_to_plain: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && res_valid |=> phase_r == PH_PLAIN)
    else $error("phase not plain after a result");

  // once a byte is decoded the escape code is known
  a_code_taken: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> phase_r != PH_AWAIT_CODE)
    else $error("still awaiting escape code after a decoded byte");

  // a held length only exists while waiting for run data
  a_pending_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_AWAIT_DATA |-> pending_r == '0)
    else $error("pending length outside run data phase");

  // a result never carries a zero count
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_count_r != '0)
    else $error("zero repeat count on output");

endmodule

FILE: tb/erle_decode_checker.sv
`timescale 1ns / 100ps

module erle_decode_checker
  import erle_pkg::*;
#(
  parameter int RUN_OFFSET = DEFAULT_RUN_OFFSET
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] stream_start
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] out_byte, [16:8] repeat_count, zero pad
  output int                     failures,
  output int                     expected_left
);

  typedef struct packed {
    logic [BYTE_W-1:0]  value;
    logic [COUNT_W-1:0] count;
  } decoded_run_t;

  decoded_run_t      expected_runs[$];
  phase_t            dec_phase;
  logic [BYTE_W-1:0] escape_code;
  logic [BYTE_W-1:0] run_length;

  initial begin
    failures      = 0;
    expected_left = 0;
    dec_phase     = PH_AWAIT_CODE;
    escape_code   = '0;
    run_length    = '0;
  end

  task report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    failures++;
  endtask

  task queue_run(input logic [BYTE_W-1:0] value, input int count);
    decoded_run_t run;
    run.value = value;
    run.count = count[COUNT_W-1:0];
    expected_runs.push_back(run);
  endtask

  // mirrors the decoder state for one accepted byte
  task decode_byte(input logic [BYTE_W-1:0] b, input logic start);
    int count;
    if (start || dec_phase == PH_AWAIT_CODE) begin
      escape_code = b;
      run_length  = '0;
      dec_phase   = PH_PLAIN;
    end else begin
      case (dec_phase)
        PH_PLAIN: begin
          if (b == escape_code) dec_phase = PH_AWAIT_LEN;
          else queue_run(b, 1);
        end
        PH_AWAIT_LEN: begin
          if (b == LITERAL_ESCAPE_LEN) begin
            dec_phase = PH_PLAIN;
            queue_run(escape_code, 1);
          end else begin
            run_length = b;
            dec_phase  = PH_AWAIT_DATA;
          end
        end
        default: begin
          count      = int'(run_length) + RUN_OFFSET;
          dec_phase  = PH_PLAIN;
          run_length = '0;
          if (count != 0) queue_run(b, count);
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    decoded_run_t want;
    logic [BYTE_W-1:0]  got_byte;
    logic [COUNT_W-1:0] got_count;
    if (!rst_n) begin
      dec_phase   = PH_AWAIT_CODE;
      escape_code = '0;
      run_length  = '0;
      expected_runs.delete();
    end else begin
      // outputs first: a byte accepted now cannot have a result yet
      if (out_tvalid && out_tready) begin
        got_byte  = out_tdata[7:0];
        got_count = out_tdata[16:8];
        if (expected_runs.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h count %0d",
                                    got_byte, got_count));
        end else begin
          want = expected_runs.pop_front();
          if (got_byte !== want.value)
            report_mismatch($sformatf("out_byte %02h, expected %02h", got_byte, want.value));
          if (got_count !== want.count)
            report_mismatch($sformatf("repeat_count %0d, expected %0d (byte %02h)",
                                      got_count, want.count, want.value));
        end
      end
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tuser);
    end
    expected_left = expected_runs.size();
  end

endmodule

FILE: tb/tb_escape_rle_byte_decoder_unit.sv
`timescale 1ns / 100ps

module tb_escape_rle_byte_decoder_unit;
  import erle_pkg::*;

  localparam int RANDOM_BYTES = 1950;
  localparam int LIMIT_CYCLES = 400000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata;   // [7:0] data_byte
  logic                   in_tuser;   // [0] stream_start
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [7:0] out_byte, [16:8] repeat_count, zero pad

  int   failures;
  int   expected_left;
  int   bytes_sent;
  int   cycle_count;
  logic calm;

  escape_rle_byte_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  erle_decode_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .failures      (failures),
    .expected_left (expected_left)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("escape_rle_byte_decoder_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 35);
  end

  // holds one byte on the input until its transfer
  task push_byte(input logic [BYTE_W-1:0] b, input logic start);
    while (!calm && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // mostly well-formed streams with random content, some noise and cut-off sequences
  task random_stream;
    logic [BYTE_W-1:0] esc;
    logic [BYTE_W-1:0] b;
    int n_sym;
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) esc = 8'h00;
    else if (pick == 1) esc = 8'hFF;
    else esc = BYTE_W'($urandom_range(255));
    push_byte(esc, 1'b1);
    n_sym = $urandom_range(24, 1);
    for (int k = 0; k < n_sym; k++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        b = BYTE_W'($urandom_range(255));
        if (b == esc) b = ~esc;
        push_byte(b, 1'b0);
      end else if (pick < 70) begin
        push_byte(esc, 1'b0);
        push_byte(LITERAL_ESCAPE_LEN, 1'b0);
      end else if (pick < 92) begin
        push_byte(esc, 1'b0);
        pick = $urandom_range(9);
        if (pick == 0) b = 8'h00;
        else if (pick == 1) b = 8'hFE;
        else b = BYTE_W'($urandom_range(254));
        push_byte(b, 1'b0);
        push_byte(BYTE_W'($urandom_range(255)), 1'b0);
      end else if (pick < 97) begin
        push_byte(BYTE_W'($urandom_range(255)), $urandom_range(7) == 0);
      end else begin
        // escape sequence left unfinished, the next stream drops it
        push_byte(esc, 1'b0);
        if ($urandom_range(1)) push_byte(BYTE_W'($urandom_range(254)), 1'b0);
        break;
      end
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    out_tready  = 1'b0;
    calm        = 1'b0;
    bytes_sent  = 0;
    cycle_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // no stream start after reset: first byte still becomes the escape code
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    // shortest and longest runs, literal escape
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'hFE, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
    // escape code 255
    push_byte(8'hFF, 1'b1); push_byte(8'h7E, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
    // restart while waiting for run data, then while waiting for a length
    push_byte(8'hFF, 1'b0); push_byte(8'h10, 1'b0); push_byte(8'h55, 1'b1);
    push_byte(8'h55, 1'b0); push_byte(8'hAA, 1'b1);
    // restart in plain phase, run data equal to the escape code
    push_byte(8'h80, 1'b1);
    push_byte(8'h80, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);

    while (bytes_sent < RANDOM_BYTES + 24) begin
      calm <= (bytes_sent >= 800 && bytes_sent < 1150);
      random_stream();
    end
    in_tvalid <= 1'b0;
    calm      <= 1'b0;

    @(negedge clk);
    while (expected_left != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (failures == 0 && expected_left == 0) begin
      $display("escape_rle_byte_decoder_unit verification clean");
    end else begin
      $display("escape_rle_byte_decoder_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: escape_rle_byte_decoder_unit.f
design/erle_pkg.sv
design/escape_rle_byte_decoder_unit.sv
tb/erle_decode_checker.sv
tb/tb_escape_rle_byte_decoder_unit.sv
